FILE: rtl/ght_pkg.sv
// package for the generational handle table: payload structs, codes, constants
// used by the controller, datapath, top level and checker; no dependencies
package ght_pkg;

  localparam int unsigned TableEntriesDefault = 4096;
  localparam int unsigned HandleBaseDefault   = 32;

  localparam logic [2:0] REQ_ALLOC  = 3'd0;
  localparam logic [2:0] REQ_LOOKUP = 3'd1;
  localparam logic [2:0] REQ_FULL   = 3'd2;
  localparam logic [2:0] REQ_FREE   = 3'd3;
  localparam logic [2:0] REQ_NEXT   = 3'd4;
  localparam logic [2:0] REQ_OWNER  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  localparam logic [15:0] GEN_ALL = 16'hffff;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] handle_in;
    logic [15:0] obj_type;
    logic [31:0] owner_id;
    logic [31:0] object_ref;
  } ght_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic [31:0] object_out;
  } ght_rsp_t;

  // entry record held in one memory word
  typedef struct packed {
    logic [15:0] kind;
    logic [15:0] gen;
    logic [31:0] owner;
    logic [31:0] obj;
  } ght_entry_t;

  // datapath commands from the controller
  typedef struct packed {
    logic        load_req;    // capture request, set index from handle or start
    logic        wr_alloc;    // write new entry at current index
    logic        wr_free;     // write freed entry (kind 0, object 0 optional)
    logic        clr_obj;     // clear object on free
    logic        link_wr;     // write free-list link
    logic        pop_head;    // free_head <= link data
    logic        push_head;   // free_head <= index
    logic        use_head;    // index <= free_head
    logic        use_append;  // index <= used_count, used_count++
    logic        idx_inc;     // index++
    logic        set_rsp;     // capture response from datapath fields
    logic [1:0]  rsp_status;
    logic        rsp_handle;  // handle_out from entry
    logic        rsp_hin;     // handle_out from request handle
    logic        rsp_obj;     // object_out from entry
  } ght_cmd_t;

  typedef struct packed {
    logic [2:0]  req;
    logic        type_zero;
    logic        handle_zero;
    logic        hi_nonzero;
    logic        dec_ok;      // decoded index valid
    logic        kind_zero;   // entry free
    logic        gen_ok;
    logic        kind_eq;     // entry kind equals obj_type
    logic        free_avail;
    logic        can_append;
    logic        idx_end;     // scan index reached used_count
    logic        owner_hit;
    logic        reuse;       // current alloc takes the free-list head
  } ght_sts_t;

endpackage

FILE: rtl/ght_ram.sv
// generic single-port RAM with registered read
// no dependencies
module ght_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/ght_datapath.sv
// datapath: entry and link memories, index, free list head, used count, response
// depends on ght_pkg and ght_ram
module ght_datapath import ght_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
  parameter int unsigned HANDLE_BASE   = HandleBaseDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  ght_req_t    req,
  input  logic [15:0] mask,
  input  ght_cmd_t    cmd,
  output ght_sts_t    sts,
  output ght_rsp_t    rsp
);
  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [15:0] BASE = 16'(HANDLE_BASE);

  ght_req_t         r;
  logic [CW-1:0]    idx;
  logic [AW-1:0]    free_head;
  logic [CW-1:0]    free_count;
  logic [CW-1:0]    used_count;
  logic             dec_ok;
  ght_entry_t       ent_rd, ent_wr;
  logic             ent_we, lnk_we;
  logic [AW-1:0]    lnk_rd;
  logic [15:0]      low_off;
  logic [14:0]      dec_idx;
  logic [15:0]      new_gen;
  // allocation path needs the old generation, so alloc reads before writing
  logic             alloc_reuse;

  // handle decode of the captured request
  assign low_off = r.handle_in[15:0] - BASE;
  assign dec_idx = low_off[15:1];

  // entry memory, one word per entry
  ght_ram #(.WIDTH($bits(ght_entry_t)), .DEPTH(TABLE_ENTRIES)) u_ent (
    .clk(clk), .we(ent_we), .addr(idx[AW-1:0]), .wdata(ent_wr), .rdata(ent_rd)
  );

  // free-list link memory
  ght_ram #(.WIDTH(AW), .DEPTH(TABLE_ENTRIES)) u_lnk (
    .clk(clk), .we(lnk_we), .addr(idx[AW-1:0]), .wdata(free_head), .rdata(lnk_rd)
  );

  // next generation on reuse, skipping zero and all-ones; 1 for an appended entry
  always_comb begin
    new_gen = ent_rd.gen + 16'd1;
    if (!alloc_reuse || new_gen == 16'd0 || new_gen == GEN_ALL) begin
      new_gen = 16'd1;
    end
  end

  // entry write data
  assign ent_we = cmd.wr_alloc | cmd.wr_free;
  always_comb begin
    ent_wr = ent_rd;
    if (cmd.wr_alloc) begin
      ent_wr.kind  = r.obj_type;
      ent_wr.gen   = new_gen;
      ent_wr.owner = r.owner_id;
      ent_wr.obj   = r.object_ref;
    end else begin
      ent_wr.kind = 16'd0;
      if (cmd.clr_obj) begin
        ent_wr.obj = 32'd0;
      end
    end
  end
  assign lnk_we = cmd.link_wr;

  // index, head, counts
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head   <= '0;
      free_count  <= '0;
      used_count  <= '0;
      idx         <= '0;
      alloc_reuse <= 1'b0;
      dec_ok      <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        r      <= req;
        dec_ok <= (req.handle_in[15:0] >= BASE) &&
                  ({1'b0, 15'((req.handle_in[15:0] - BASE) >> 1)} <
                   16'(used_count));
        if (req.req_type == REQ_OWNER ||
            (req.req_type == REQ_NEXT && req.handle_in == 32'd0)) begin
          idx <= '0;
        end else begin
          idx <= CW'((req.handle_in[15:0] - BASE) >> 1);
        end
      end
      if (cmd.use_head) begin
        idx         <= CW'(free_head);
        alloc_reuse <= 1'b1;
      end
      if (cmd.use_append) begin
        idx         <= used_count;
        used_count  <= used_count + 1'b1;
        alloc_reuse <= 1'b0;
      end
      if (cmd.pop_head) begin
        free_head  <= lnk_rd;
        free_count <= free_count - 1'b1;
      end
      if (cmd.push_head) begin
        free_head <= idx[AW-1:0];
        if (free_count < CW'(TABLE_ENTRIES)) begin
          free_count <= free_count + 1'b1;
        end
      end
      if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.set_rsp) begin
        rsp.status     <= cmd.rsp_status;
        rsp.handle_out <= cmd.rsp_hin ? r.handle_in :
                          cmd.rsp_handle ? ({(cmd.wr_alloc ? new_gen : ent_rd.gen), 16'd0}
                                            + 32'(BASE) + {31'(idx), 1'b0})
                                         : 32'd0;
        rsp.object_out <= cmd.rsp_obj ? ent_rd.obj : 32'd0;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts.req         = r.req_type;
    sts.type_zero   = (r.obj_type == 16'd0);
    sts.handle_zero = (r.handle_in == 32'd0);
    sts.hi_nonzero  = (r.handle_in[31:16] != 16'd0);
    sts.dec_ok      = dec_ok && (dec_idx < 15'(TABLE_ENTRIES));
    sts.kind_zero   = (ent_rd.kind == 16'd0);
    sts.gen_ok      = (r.handle_in[31:16] == 16'd0) || (r.handle_in[31:16] == GEN_ALL) ||
                      (r.handle_in[31:16] == ent_rd.gen);
    sts.kind_eq     = (ent_rd.kind == r.obj_type);
    sts.free_avail  = (free_count != '0);
    sts.can_append  = (used_count < CW'(TABLE_ENTRIES));
    sts.idx_end     = (idx >= used_count);
    sts.owner_hit   = !sts.kind_zero && (ent_rd.kind < 16'd16) &&
                      mask[ent_rd.kind[3:0]] && (ent_rd.owner == r.owner_id);
    sts.reuse       = alloc_reuse;
  end
endmodule

FILE: rtl/ght_ctrl.sv
// controller state machine sequencing memory accesses per request
// depends on ght_pkg
module ght_ctrl import ght_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  ght_sts_t sts,
  output ght_cmd_t cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_ALLOC = 3'd5;
  localparam logic [2:0] S_LINK  = 3'd6;

  logic [2:0] state, state_next;
  logic       out_valid_next;

  // a new request enters once the previous response is gone or leaving
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load_req = 1'b1;
          state_next   = S_DEC;
        end
      end
      // pick slot or validate handle; memory read issued on the index
      S_DEC: begin
        if (sts.req == REQ_ALLOC) begin
          if (sts.type_zero) begin
            cmd.set_rsp = 1'b1; cmd.rsp_status = ST_INVALID; state_next = S_IDLE;
            out_valid_next = 1'b1;
          end else if (sts.free_avail) begin
            cmd.use_head = 1'b1; state_next = S_LINK;
          end else if (sts.can_append) begin
            cmd.use_append = 1'b1; state_next = S_ALLOC;
          end else begin
            cmd.set_rsp = 1'b1; cmd.rsp_status = ST_FULL; state_next = S_IDLE;
            out_valid_next = 1'b1;
          end
        end else if (sts.req == REQ_FULL && sts.hi_nonzero) begin
          cmd.set_rsp = 1'b1; cmd.rsp_hin = 1'b1; cmd.rsp_status = ST_OK;
          state_next = S_IDLE; out_valid_next = 1'b1;
        end else if (sts.req == REQ_OWNER) begin
          state_next = S_SCAN;
        end else if (sts.req == REQ_NEXT) begin
          if (sts.handle_zero) begin
            state_next = S_SCAN;
          end else if (sts.dec_ok) begin
            cmd.idx_inc = 1'b1; state_next = S_SCAN;
          end else begin
            cmd.set_rsp = 1'b1; cmd.rsp_status = ST_INVALID; state_next = S_IDLE;
            out_valid_next = 1'b1;
          end
        end else if (sts.req == REQ_LOOKUP || sts.req == REQ_FULL ||
                     sts.req == REQ_FREE) begin
          if (sts.dec_ok) begin
            state_next = S_RD;
          end else begin
            cmd.set_rsp = 1'b1; cmd.rsp_hin = (sts.req == REQ_FULL);
            cmd.rsp_status = ST_INVALID; state_next = S_IDLE; out_valid_next = 1'b1;
          end
        end else begin
          cmd.set_rsp = 1'b1; cmd.rsp_status = ST_INVALID; state_next = S_IDLE;
          out_valid_next = 1'b1;
        end
      end
      // the addressed entry is read in S_DEC; its data is valid from S_RD on
      S_RD: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next     = S_IDLE;
        out_valid_next = 1'b1;
        cmd.set_rsp    = 1'b1;
        cmd.rsp_status = ST_INVALID;
        cmd.rsp_hin    = (sts.req == REQ_FULL);
        if (!sts.kind_zero && sts.gen_ok) begin
          if (sts.req == REQ_FULL) begin
            cmd.rsp_status = ST_OK; cmd.rsp_hin = 1'b0; cmd.rsp_handle = 1'b1;
          end else if (sts.req == REQ_LOOKUP && sts.kind_eq) begin
            cmd.rsp_status = ST_OK; cmd.rsp_handle = 1'b1; cmd.rsp_obj = 1'b1;
          end else if (sts.req == REQ_FREE && (sts.type_zero || sts.kind_eq)) begin
            cmd.rsp_status = ST_OK; cmd.rsp_handle = 1'b1; cmd.rsp_obj = 1'b1;
            cmd.wr_free = 1'b1; cmd.clr_obj = 1'b1; cmd.link_wr = 1'b1;
            cmd.push_head = 1'b1;
          end
        end
      end
      // scan: each entry is read in S_SCAN and checked in S_LINK
      S_SCAN: begin
        if (sts.idx_end) begin
          cmd.set_rsp = 1'b1;
          cmd.rsp_status = (sts.req == REQ_OWNER) ? ST_OK : ST_NONE;
          state_next = S_IDLE; out_valid_next = 1'b1;
        end else begin
          state_next = S_LINK;
        end
      end
      // alloc reuse: wait for link and old entry read at the head index; scans check the entry here
      S_LINK: begin
        if (sts.req == REQ_ALLOC) begin
          state_next = S_ALLOC;
        end else if (sts.req == REQ_OWNER) begin
          if (sts.owner_hit) begin
            cmd.wr_free = 1'b1; cmd.link_wr = 1'b1; cmd.push_head = 1'b1;
          end
          cmd.idx_inc = 1'b1; state_next = S_SCAN;
        end else begin
          if (!sts.kind_zero && (sts.type_zero || sts.kind_eq)) begin
            cmd.set_rsp = 1'b1; cmd.rsp_status = ST_OK; cmd.rsp_handle = 1'b1;
            cmd.rsp_obj = 1'b1; state_next = S_IDLE; out_valid_next = 1'b1;
          end else begin
            cmd.idx_inc = 1'b1; state_next = S_SCAN;
          end
        end
      end
      // write the entry; a reused slot pops the free list here
      S_ALLOC: begin
        cmd.wr_alloc = 1'b1; cmd.set_rsp = 1'b1; cmd.rsp_status = ST_OK;
        cmd.pop_head = sts.reuse;
        cmd.rsp_handle = 1'b1; state_next = S_IDLE; out_valid_next = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

FILE: rtl/generational_handle_table.sv
// top level of the generational handle table
// depends on ght_pkg, ght_ctrl, ght_datapath
//
// Use: present a request on req with req_valid; it transfers at an edge with
// req_valid high and req_stall low. One response follows on rsp/rsp_valid and
// transfers at an edge where rsp_stall is low. One request is in work at a
// time. Rejects and full-handle requests that already carry a generation are
// answered from the decode state; an alloc that appends goes on to the alloc
// write; one that reuses a freed entry first reads its link and old entry;
// lookup, full handle and free read the entry, then check and update it in
// the single-port entry memory. Next of type and free owner walk the table,
// reading and checking each entry visited; a next-of-type hit ends the walk.
// A new request can transfer in the cycle the response transfers.
// While a response is stalled it holds and req_stall stays high.
// Reset clears the free list and used count; entry memory is not cleared,
// only entries below the used count are read. The mask register sits at
// APB address 0; pready is always high.
module generational_handle_table import ght_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
  parameter int unsigned HANDLE_BASE   = HandleBaseDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  ght_req_t    req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output ght_rsp_t    rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] mask;
  ght_cmd_t    cmd;
  ght_sts_t    sts;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {16'd0, mask} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      mask <= pwdata[15:0];
    end
  end

  ght_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req_valid), .in_stall(req_stall),
    .out_valid(rsp_valid), .out_stall(rsp_stall), .sts(sts), .cmd(cmd)
  );

  ght_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .HANDLE_BASE(HANDLE_BASE)) u_dp (
    .clk(clk), .rst(rst), .req(req), .mask(mask), .cmd(cmd), .sts(sts), .rsp(rsp)
  );
endmodule

FILE: rtl/ght_checker.sv
// port-level checker for the generational handle table, bound to the top level
// depends on ght_pkg
module ght_checker import ght_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input ght_rsp_t rsp
);
  // one request in work: no new transfer right after one
  a_one: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall) else $error("second request taken");
  // response held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp)) else $error("rsp dropped");
  // no request enters while a response waits
  a_wait: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> req_stall) else $error("request during stall");
endmodule

bind generational_handle_table ght_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
  .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
